// ----- src/lifegen_pkg.sv -----
// Shared types and constants for the toroidal life generation block.
`default_nettype none

package lifegen_pkg;

  // Field widths of the stream items and configuration registers
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  // B3/S23 neighbor counts
  localparam logic [3:0] LIFE_BORN = 4'd3;
  localparam logic [3:0] LIFE_KEEP = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // op code with no operation behind it, answered with done cleared
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic {
    CFG_BOARD_WIDTH  = 1'b0,
    CFG_BOARD_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_LOAD_FIRST,
    ST_LOAD_UP,
    ST_ROW
  } state_e;

endpackage

`default_nettype wire

// ----- src/life_toroidal_generation_step.sv -----
// Toroidal B3/S23 life board held in a row-wide memory, with cell access and generation step.
//
// The board lives in one MAX_ROWS deep memory, one row of MAX_COLS cells per entry, with a
// registered read. After reset a clearing pass writes every row dead, during which no item
// is accepted. A write or read item reads the row, then modifies and writes it back or
// returns the bit. An unused op code returns at once. A step item first fetches two rows
// (row 0 and the last row) to prime the row buffers, then one row per cycle is fetched,
// updated and written back, so the memory read port sets the step length. Results sit in an
// output register; a new item is accepted only when that register is empty or its result
// leaves in the same cycle.
`default_nettype none

module life_toroidal_generation_step
  import lifegen_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write channel
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic                   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  // fields from bit 0: col[5:0], row_index[11:6], cell_value[12], zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // fields from bit 0: op[1:0]
  input  wire logic [OP_W-1:0]        s_axis_tuser_i,
  // result stream
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // fields from bit 0: read_value[0], done_res[1], zero fill
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned WW  = ($clog2(MAX_COLS + 1) > CFG_DATA_W) ?
                                $clog2(MAX_COLS + 1) : CFG_DATA_W;
  localparam int unsigned HW  = ($clog2(MAX_ROWS + 1) > CFG_DATA_W) ?
                                $clog2(MAX_ROWS + 1) : CFG_DATA_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

  // configuration
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;

  // state machine and control
  state_e          state_q, state_d;
  logic [RW-1:0]   y_q, y_d;
  op_e             op_q;
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic            val_q;
  logic            inside_q;

  // row buffers
  logic [MAX_COLS-1:0] first_q, prev_q, cur_q;

  // memory
  logic [MAX_COLS-1:0] cell_mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_q;
  logic                mem_we;
  logic [RW-1:0]       mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata;

  // result register
  logic m_valid_q, rd_q, done_q;
  logic res_load, res_rd, res_done;

  // input decode
  logic          in_acc;
  op_e           in_op;
  logic [COORD_W-1:0] in_col, in_row;
  logic          in_val, in_inside;
  logic          row_last;
  logic [MAX_COLS-1:0] below, next_row, cell_row;

  assign in_op  = op_e'(s_axis_tuser_i);
  assign in_col = s_axis_tdata_i[COORD_W-1:0];
  assign in_row = s_axis_tdata_i[2*COORD_W-1:COORD_W];
  assign in_val = s_axis_tdata_i[2*COORD_W];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - 2){1'b0}}, done_q, rd_q};

  // size clamp: zero means one, above maximum saturates
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (WW'(width_q) > WW'(MAX_COLS)) begin
      w_eff = WW'(MAX_COLS);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (HW'(height_q) > HW'(MAX_ROWS)) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign in_inside = (WW'(in_col) < w_eff) && (HW'(in_row) < h_eff);
  assign row_last  = (HW'(y_q) + HW'(1)) == h_eff;
  assign below     = row_last ? first_q : rdata_q;

  // one generation of one row, wrapping at the column in use boundary
  always_comb begin
    logic [CW-1:0]       wm1;
    logic [MAX_COLS-1:0] a_l, a_r, h_l, h_r, b_l, b_r;
    logic [MAX_COLS-1:0] a_sh, h_sh, b_sh;
    logic [3:0]          n;
    logic                at_end;
    wm1  = CW'(w_eff - WW'(1));
    a_l  = {prev_q[MAX_COLS-2:0], prev_q[wm1]};
    h_l  = {cur_q[MAX_COLS-2:0], cur_q[wm1]};
    b_l  = {below[MAX_COLS-2:0], below[wm1]};
    a_sh = {1'b0, prev_q[MAX_COLS-1:1]};
    h_sh = {1'b0, cur_q[MAX_COLS-1:1]};
    b_sh = {1'b0, below[MAX_COLS-1:1]};
    for (int x = 0; x < MAX_COLS; x++) begin
      at_end = (x + 1) == int'(w_eff);
      a_r[x] = at_end ? prev_q[0] : a_sh[x];
      h_r[x] = at_end ? cur_q[0]  : h_sh[x];
      b_r[x] = at_end ? below[0]  : b_sh[x];
    end
    for (int x = 0; x < MAX_COLS; x++) begin
      n = 4'(a_l[x]) + 4'(prev_q[x]) + 4'(a_r[x]) + 4'(h_l[x]) + 4'(h_r[x])
        + 4'(b_l[x]) + 4'(below[x]) + 4'(b_r[x]);
      if (x < int'(w_eff)) begin
        next_row[x] = (n == LIFE_BORN) || (cur_q[x] && (n == LIFE_KEEP));
      end else begin
        next_row[x] = cur_q[x];
      end
    end
  end

  // single cell write-back data
  always_comb begin
    cell_row        = rdata_q;
    cell_row[col_q] = val_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (y_q == LAST_ROW) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_WRITE, OP_READ: state_d = ST_CELL;
            OP_STEP:           state_d = ST_LOAD_FIRST;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_CELL:       state_d = ST_IDLE;
      ST_LOAD_FIRST: state_d = ST_LOAD_UP;
      ST_LOAD_UP:    state_d = ST_ROW;
      ST_ROW: begin
        if (row_last) state_d = ST_IDLE;
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = y_q;
    mem_wdata = next_row;
    mem_raddr = '0;
    res_load  = 1'b0;
    res_rd    = 1'b0;
    res_done  = 1'b1;
    y_d       = y_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        y_d       = y_q + RW'(1);
      end
      ST_IDLE: begin
        mem_raddr = RW'(in_row);
        y_d       = '0;
        if (in_acc && (in_op != OP_WRITE) && (in_op != OP_STEP) && (in_op != OP_READ)) begin
          res_load = 1'b1;
          res_done = 1'b0;
        end
        if (in_op == OP_STEP) mem_raddr = '0;
      end
      ST_CELL: begin
        res_load  = 1'b1;
        res_rd    = (op_q == OP_READ) && inside_q && rdata_q[col_q];
        mem_we    = (op_q == OP_WRITE) && inside_q;
        mem_waddr = row_q;
        mem_wdata = cell_row;
      end
      ST_LOAD_FIRST: begin
        mem_raddr = RW'(h_eff - HW'(1));
      end
      ST_LOAD_UP: begin
        if (h_eff > HW'(1)) mem_raddr = RW'(1);
        y_d = '0;
      end
      ST_ROW: begin
        mem_we = 1'b1;
        if ((HW'(y_q) + HW'(2)) < h_eff) mem_raddr = y_q + RW'(2);
        res_load = row_last;
        y_d      = y_q + RW'(1);
      end
      default: ;
    endcase
  end

  // board memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) cell_mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= cell_mem_q[mem_raddr];
  end

  // row buffers and captured item fields
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD_FIRST) begin
      first_q <= rdata_q;
      cur_q   <= rdata_q;
    end else if (state_q == ST_ROW) begin
      cur_q   <= below;
    end
    if (state_q == ST_LOAD_UP) begin
      prev_q <= rdata_q;
    end else if (state_q == ST_ROW) begin
      prev_q <= cur_q;
    end
    if (in_acc) begin
      op_q     <= in_op;
      col_q    <= CW'(in_col);
      row_q    <= RW'(in_row);
      val_q    <= in_val;
      inside_q <= in_inside;
    end
    if (res_load) begin
      rd_q   <= res_rd;
      done_q <= res_done;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      y_q       <= '0;
      m_valid_q <= 1'b0;
      width_q   <= CFG_DATA_W'(64);
      height_q  <= CFG_DATA_W'(64);
    end else begin
      state_q <= state_d;
      y_q     <= y_d;
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_BOARD_WIDTH:  width_q  <= cfg_data_i;
          CFG_BOARD_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/lifegen_chk.sv -----
// Port-level checker for the toroidal life block, bound to its top level.
`default_nettype none

module lifegen_chk
  import lifegen_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   cfg_valid_i,
  input wire logic                   cfg_ready_o,
  input wire logic                   cfg_index_i,
  input wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input wire logic [OP_W-1:0]        s_axis_tuser_i,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // never take an item while a result is stuck in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("item accepted over a stalled result");

  // a valid op keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser_i != OP_UNUSED)) |=> !s_axis_tready_o)
    else $error("block ready right after a real operation");

  // the unused op code answers at once with done cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser_i == OP_UNUSED)) |=>
      (m_axis_tvalid_o && (m_axis_tdata_o[1:0] == 2'b00)))
    else $error("unused op not answered with done low");

  // a read value only comes with a completed operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> m_axis_tdata_o[1])
    else $error("read value set without done");

endmodule

bind life_toroidal_generation_step lifegen_chk u_lifegen_chk (.*);

`default_nettype wire

// ----- tb/tb_life_toroidal_generation_step.sv -----
// Self-checking testbench for the toroidal B3/S23 life board block.
`timescale 1ns / 1ps

module tb_life_toroidal_generation_step;
  import lifegen_pkg::*;

  localparam int BOARD_DIM       = 64;
  localparam int IDLE_MAX        = 18;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 4;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int FIXED_PHASES    = 14;
  localparam int NUM_PHASES      = 16;
  localparam int PRESSURE_PHASE  = 7;
  localparam int PAUSE_PHASE     = 9;
  localparam int HOLD_START      = 10;

  typedef struct packed {
    logic read_value;
    logic done_res;
  } cell_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               val;
    logic               typed;
    cell_result_t       res;
  } directed_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_index_i = 1'b0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [OP_W-1:0]        s_axis_tuser_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  always #5 clk_i = ~clk_i;

  life_toroidal_generation_step u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Board state and sizes as the block should hold them
  logic [BOARD_DIM-1:0]  board_cells [BOARD_DIM];
  logic [CFG_DATA_W-1:0] width_reg  = 7'd64;
  logic [CFG_DATA_W-1:0] height_reg = 7'd64;

  cell_result_t   expected_q [$];
  directed_item_t directed_q [$];
  int  mismatch_count = 0;
  int  source_gap_max = IDLE_MAX;
  int  sink_stall_max = IDLE_MAX;
  bit  hold_sink = 1'b0;

  int phase_w [FIXED_PHASES] = '{1, 2, 0, 2, 1, 3, 127, 64, 5, 8, 1, 64, 65, 16};
  int phase_h [FIXED_PHASES] = '{1, 2, 0, 1, 2, 3, 127, 64, 8, 5, 64, 1, 100, 16};

  // zero reads as 1, anything past the array saturates
  function automatic int used_size(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > BOARD_DIM) return BOARD_DIM;
    return int'(v);
  endfunction

  function automatic void step_board();
    logic [BOARD_DIM-1:0] prior [BOARD_DIM];
    int w;
    int h;
    int n;
    w = used_size(width_reg);
    h = used_size(height_reg);
    prior = board_cells;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        n = 0;
        // modulo wrap: on tiny boards a neighbor may repeat or be the cell itself
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dy != 0 || dx != 0) n += int'(prior[(y + dy + h) % h][(x + dx + w) % w]);
          end
        end
        board_cells[y][x] = (n == 3) || (prior[y][x] && n == 2);
      end
    end
  endfunction

  function automatic cell_result_t apply_item(logic [OP_W-1:0] op_code,
                                              logic [COORD_W-1:0] col,
                                              logic [COORD_W-1:0] row, logic val);
    cell_result_t r;
    logic in_area;
    in_area = (int'(col) < used_size(width_reg)) && (int'(row) < used_size(height_reg));
    r.read_value = 1'b0;
    r.done_res   = 1'b1;
    case (op_code)
      OP_WRITE: begin
        if (in_area) board_cells[row][col] = val;
      end
      OP_STEP: begin
        step_board();
      end
      OP_READ: begin
        if (in_area) r.read_value = board_cells[row][col];
      end
      default: begin
        r.done_res = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic directed_item_t dir_entry(logic [OP_W-1:0] op_code, int col, int row,
                                               logic val, logic typed, logic rd, logic dn);
    directed_item_t d;
    d.op             = op_code;
    d.col            = COORD_W'(col);
    d.row            = COORD_W'(row);
    d.val            = val;
    d.typed          = typed;
    d.res.read_value = rd;
    d.res.done_res   = dn;
    return d;
  endfunction

  // mostly inside the area, often near the wrap edge, sometimes anywhere
  function automatic logic [COORD_W-1:0] pick_coord(int size);
    int k;
    k = $urandom_range(0, 7);
    case ($urandom_range(0, 7))
      0, 1: return COORD_W'($urandom_range(0, BOARD_DIM - 1));
      2, 3: return COORD_W'((k + size * 8 - 4) % size);
      default: return COORD_W'($urandom_range(0, size - 1));
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic offer_item(logic [OP_W-1:0] op_code, logic [COORD_W-1:0] col,
                            logic [COORD_W-1:0] row, logic val, int gap,
                            logic typed, cell_result_t typed_res);
    cell_result_t predicted;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - 2 * COORD_W - 1){1'b0}}, val, row, col};
    s_axis_tuser_i  <= op_code;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_item(op_code, col, row, val);
    expected_q = {expected_q, typed ? typed_res : predicted};
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_BOARD_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    forever begin
      if (hold_sink && !held) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = $urandom_range(0, sink_stall_max);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending, done_res", int'(m_axis_tdata_o[1]), 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata_o[0] !== want.read_value)
          report_mismatch("read_value", int'(m_axis_tdata_o[0]), int'(want.read_value));
        if (m_axis_tdata_o[1] !== want.done_res)
          report_mismatch("done_res", int'(m_axis_tdata_o[1]), int'(want.done_res));
      end
    end
  end

  // no transaction on any channel for too long means the block hung
  always @(posedge clk_i) begin
    int quiet_cycles;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    directed_item_t d;
    logic [OP_W-1:0] op_code;
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] h_val;
    int w;
    int h;
    int pick;
    int gap;

    foreach (board_cells[i]) board_cells[i] = '0;

    // cleared board at 64x64, then a blinker and a blinker wrapping both edges
    directed_q = {directed_q, dir_entry(OP_READ,  63, 63, 1'b0, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_READ,   0,  0, 1'b0, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_UNUSED, 63, 63, 1'b1, 1'b1, 1'b0, 1'b0)};
    directed_q = {directed_q, dir_entry(OP_WRITE,  0,  0, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_READ,   0,  0, 1'b0, 1'b1, 1'b1, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_WRITE, 63, 63, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_READ,  63, 63, 1'b1, 1'b1, 1'b1, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_WRITE, 63, 63, 1'b0, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_WRITE,  0,  0, 1'b0, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_WRITE, 10,  5, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_WRITE, 11,  5, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_WRITE, 12,  5, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_STEP,   0,  0, 1'b0, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_READ,  11,  4, 1'b0, 1'b0, 1'b0, 1'b0)};
    directed_q = {directed_q, dir_entry(OP_READ,  11,  6, 1'b0, 1'b0, 1'b0, 1'b0)};
    directed_q = {directed_q, dir_entry(OP_READ,  10,  5, 1'b0, 1'b0, 1'b0, 1'b0)};
    directed_q = {directed_q, dir_entry(OP_WRITE, 63,  0, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_WRITE,  0,  0, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_WRITE,  1,  0, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_STEP,  63, 63, 1'b1, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_READ,   0, 63, 1'b0, 1'b0, 1'b0, 1'b0)};
    directed_q = {directed_q, dir_entry(OP_READ,   0,  1, 1'b0, 1'b0, 1'b0, 1'b0)};
    directed_q = {directed_q, dir_entry(OP_READ,  63,  0, 1'b0, 1'b0, 1'b0, 1'b0)};
    directed_q = {directed_q, dir_entry(OP_STEP,   0,  0, 1'b0, 1'b1, 1'b0, 1'b1)};
    directed_q = {directed_q, dir_entry(OP_READ,  11,  5, 1'b0, 1'b0, 1'b0, 1'b0)};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_q[i]) begin
      d = directed_q[i];
      offer_item(d.op, d.col, d.row, d.val, $urandom_range(0, IDLE_MAX), d.typed, d.res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        w_val = CFG_DATA_W'(phase_w[p]);
        h_val = CFG_DATA_W'(phase_h[p]);
      end else begin
        w_val = CFG_DATA_W'($urandom_range(0, 127));
        h_val = CFG_DATA_W'($urandom_range(0, 127));
      end
      // sizes change only with the block idle
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      write_reg(CFG_BOARD_WIDTH, w_val);
      write_reg(CFG_BOARD_HEIGHT, h_val);
      cfg_valid_i <= 1'b0;
      w = used_size(width_reg);
      h = used_size(height_reg);
      source_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == PRESSURE_PHASE && k == HOLD_START) hold_sink = 1'b1;
        if (p == PAUSE_PHASE && k == 40) drain_results();
        pick = $urandom_range(0, 99);
        op_code = (pick < 40) ? OP_WRITE :
                  (pick < 75) ? OP_READ  :
                  (pick < 92) ? OP_STEP  : OP_UNUSED;
        // keep offering back to back while the sink is held off
        gap = (p == PRESSURE_PHASE && k >= HOLD_START) ? 0 :
              $urandom_range(0, source_gap_max);
        offer_item(op_code, pick_coord(w), pick_coord(h), 1'($urandom_range(0, 1)), gap,
                   1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
